### hdl/mmdp_pkg.sv
// Shared types and constants for the modular matrix dot product block.
package mmdp_pkg;

  // Fixed port field widths.
  localparam int ELEM_W      = 64;
  localparam int IN_TDATA_W  = 2 * ELEM_W;
  localparam int OUT_TDATA_W = ELEM_W;

  // Default element width and the modulus after reset.
  localparam int                ELEM_BITS_DEF = 64;
  localparam logic [ELEM_W-1:0] MODULUS_RESET = 64'd2;

  // Partial products of the split multiplier: two halves of each operand.
  localparam int MUL_STEPS = 4;
  localparam int SEL_W     = 2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_ACC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;      // capture the input beat
    logic             pp_mul;    // form one partial product
    logic [SEL_W-1:0] pp_sel;    // which operand halves: {a half, b half}
    logic             pp_add;    // add the previous partial product
    logic             mod_step;  // one shift-subtract remainder step
    logic             acc;       // add the remainder into the running sum
    logic             emit;      // hand the sum to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // the item in work closes an inner product
    logic out_full;  // the output register holds an untaken beat
  } dp_stat_t;

endpackage

### hdl/mmdp_ctrl.sv
// Controller state machine that sequences multiply, reduce and accumulate.
module mmdp_ctrl import mmdp_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int                CNT_W    = $clog2(2 * ELEM_BITS);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS);
  localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(2 * ELEM_BITS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             can_finish;

  // The sum may retire unless it must emit into a full, stalled output register.
  assign can_finish = !stat.last || !stat.out_full || m_tready;

  // Next state and step counter.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = ST_MOD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MOD: begin
        if (cnt == MOD_LAST) begin
          state_next = ST_ACC;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ACC: begin
        if (can_finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_MUL: begin
        cmd.pp_mul = (cnt != MUL_LAST);
        cmd.pp_sel = cnt[SEL_W-1:0];
        cmd.pp_add = (cnt != '0);
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      ST_ACC: begin
        cmd.acc  = can_finish;
        cmd.emit = can_finish && stat.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### hdl/mmdp_dpath.sv
// Datapath: split multiplier, shift-subtract remainder, modular accumulator.
module mmdp_dpath import mmdp_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [ELEM_W-1:0]      cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat
);

  localparam int N      = ELEM_BITS;
  localparam int HALF   = (N + 1) / 2;
  localparam int OPW    = 2 * HALF;
  localparam int PPW    = 2 * HALF;
  localparam int SUMW   = 2 * OPW;
  localparam int PROD_W = 2 * N;

  logic [ELEM_W-1:0] modulus;
  logic [N-1:0]      q;
  logic              q_zero;
  logic [OPW-1:0]    a_reg, b_reg;
  logic              last_reg;
  logic [HALF-1:0]   a_half, b_half;
  logic [PPW-1:0]    pp;
  logic [SEL_W-1:0]  pp_sel_q;
  logic [SUMW-1:0]   pp_shifted, prod_sum;
  logic [PROD_W-1:0] prod;
  logic [N-1:0]      rem;
  logic [N:0]        rem_shift, rem_diff;
  logic [N-1:0]      rem_next;
  logic [N-1:0]      sum, addend, sum_new;
  logic [N:0]        acc_raw, acc_diff;

  assign q      = modulus[N-1:0];
  assign q_zero = (q == '0);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_valid) begin
      modulus <= cfg_data;
    end
  end

  // Operand capture; bits above the element width are dropped.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg    <= OPW'(s_tdata[N-1:0]);
      b_reg    <= OPW'(s_tdata[ELEM_W +: N]);
      last_reg <= s_tlast;
    end
  end

  // One half-by-half partial product per cycle, registered.
  assign a_half = cmd.pp_sel[1] ? a_reg[OPW-1:HALF] : a_reg[HALF-1:0];
  assign b_half = cmd.pp_sel[0] ? b_reg[OPW-1:HALF] : b_reg[HALF-1:0];

  always_ff @(posedge clk) begin
    if (cmd.pp_mul) begin
      pp       <= a_half * b_half;
      pp_sel_q <= cmd.pp_sel;
    end
  end

  // Align the partial product by the weight of its halves.
  always_comb begin
    pp_shifted = SUMW'(pp);
    if (pp_sel_q[1] && pp_sel_q[0]) begin
      pp_shifted = SUMW'(pp) << OPW;
    end else if (pp_sel_q[1] || pp_sel_q[0]) begin
      pp_shifted = SUMW'(pp) << HALF;
    end
  end

  assign prod_sum = SUMW'(prod) + pp_shifted;

  // Remainder step: shift in the next product bit and subtract q once.
  assign rem_shift = {rem, prod[PROD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, q};
  assign rem_next  = (rem_shift >= {1'b0, q}) ? rem_diff[N-1:0] : rem_shift[N-1:0];

  // Product accumulates partial products, then rotates once per remainder
  // step so that its low word is intact after all 2N steps.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod <= '0;
      rem  <= '0;
    end else if (cmd.pp_add) begin
      prod <= prod_sum[PROD_W-1:0];
    end else if (cmd.mod_step) begin
      prod <= {prod[PROD_W-2:0], prod[PROD_W-1]};
      rem  <= rem_next;
    end
  end

  // Modular add; a zero modulus means plain wraparound at the element width.
  assign addend   = q_zero ? prod[N-1:0] : rem;
  assign acc_raw  = {1'b0, sum} + {1'b0, addend};
  assign acc_diff = acc_raw - {1'b0, q};

  always_comb begin
    if (q_zero) begin
      sum_new = acc_raw[N-1:0];
    end else if (acc_raw >= {1'b0, q}) begin
      sum_new = acc_diff[N-1:0];
    end else begin
      sum_new = acc_raw[N-1:0];
    end
  end

  // Running sum, cleared when an inner product closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= cmd.emit ? '0 : sum_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= OUT_TDATA_W'(sum_new);
    end
  end

  assign stat.last     = last_reg;
  assign stat.out_full = m_tvalid;

endmodule

### hdl/modular_matrix_dot_product.sv
// Modular multiply-accumulate top level: one element of a matrix product mod q.
// Timing: an item retires once its multiply, remainder and accumulate states are done;
// a closing item's sum is on m_tdata from that edge. Items are taken one at a time,
// each only once the last retires; the one-bit-per-cycle shift-subtract remainder sets
// the pace, and a full, stalled output register holds back a closing item.
// Reset (rst, synchronous): modulus returns to 2, the sum to 0, no beat pending.
module modular_matrix_dot_product import mmdp_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel: modulus.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ELEM_W-1:0]      cfg_data,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // a_elem [63:0], b_elem [127:64]
  input  logic                   s_tlast,
  // Output stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // dot [63:0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  mmdp_ctrl #(
    .ELEM_BITS(ELEM_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Arithmetic and output register.
  mmdp_dpath #(
    .ELEM_BITS(ELEM_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

### tb/sv/modular_matrix_dot_product_tb.sv
// Self-checking testbench for the modular matrix dot product block.
module modular_matrix_dot_product_tb;
  import mmdp_pkg::*;

  localparam int                ELEM_BITS      = ELEM_BITS_DEF;
  localparam logic [ELEM_W-1:0] ELEM_MASK      = {ELEM_W{1'b1}} >> (ELEM_W - ELEM_BITS);
  localparam logic [ELEM_W-1:0] ALL_ONES       = {ELEM_W{1'b1}};
  // Long enough for one item to retire after it is taken, with some margin.
  localparam int                DRAIN_CYCLES   = 2 * ELEM_BITS + 30;
  // Cycles with no beat on any channel before the run is declared hung.
  localparam int                WATCHDOG_LIMIT = 4000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [ELEM_W-1:0]      cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // a_elem [63:0], b_elem [127:64]
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // dot [63:0]

  // Percent of cycles in which the sender or the receiver holds back.
  int send_idle = 31;
  int recv_idle = 88;
  int quiet_cycles = 0;

  // Tracks the running modular sum and holds the inner products still owed.
  class modular_dot_board;
    logic [ELEM_W-1:0] modulus;
    logic [ELEM_W-1:0] partial_sum;
    logic [ELEM_W-1:0] dots_due[$];
    int                mismatches;

    function new();
      modulus     = MODULUS_RESET;
      partial_sum = '0;
      mismatches  = 0;
    endfunction

    // Fold one accepted pair into the sum; a closing pair owes a dot result.
    function void note_pair(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b, logic last);
      logic [ELEM_W-1:0]   q;
      logic [2*ELEM_W-1:0] wide_a;
      logic [2*ELEM_W-1:0] wide_b;
      logic [2*ELEM_W-1:0] product;
      logic [ELEM_W:0]     total;
      q       = modulus & ELEM_MASK;
      wide_a  = a & ELEM_MASK;
      wide_b  = b & ELEM_MASK;
      product = wide_a * wide_b;
      if (q == '0) begin
        // A zero modulus stands for 2^ELEM_BITS, so everything simply wraps.
        partial_sum = (partial_sum + product[ELEM_W-1:0]) & ELEM_MASK;
      end else begin
        wide_b = q;
        product = product % wide_b;
        total = {1'b0, partial_sum} + {1'b0, product[ELEM_W-1:0]};
        // The sum drops by q at most once per pair, even after a modulus change.
        if (total >= {1'b0, q}) total = total - {1'b0, q};
        partial_sum = total[ELEM_W-1:0] & ELEM_MASK;
      end
      if (last) begin
        dots_due.push_back(partial_sum);
        partial_sum = '0;
      end
    endfunction

    // Compare one dot beat with the oldest owed result.
    function void check_dot(logic [ELEM_W-1:0] dot);
      logic [ELEM_W-1:0] due;
      if (dots_due.size() == 0) begin
        $error("dot: no result expected, actual %h", dot);
        mismatches++;
      end else begin
        due = dots_due.pop_front();
        if (dot !== due) begin
          $error("dot: expected %h, actual %h", due, dot);
          mismatches++;
        end
      end
    endfunction
  endclass

  modular_dot_board board = new();

  modular_matrix_dot_product #(
    .ELEM_BITS(ELEM_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random on the falling edge.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Every channel is observed at the rising edge; the watchdog runs here too.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_dot(m_tdata);
      if (s_tvalid && s_tready)
        board.note_pair(s_tdata[ELEM_W-1:0], s_tdata[2*ELEM_W-1:ELEM_W], s_tlast);
      if (cfg_valid && cfg_ready) board.modulus = cfg_data;
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one pair on the input stream and wait until the beat is taken.
  task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic last);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending, let every owed result and any silent item finish.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.dots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Change the modulus once the block has gone quiet.
  task automatic write_modulus(input logic [ELEM_W-1:0] q);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= q;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Operands lean toward zero, all ones and values around the modulus.
  function automatic logic [ELEM_W-1:0] pick_elem(input logic [ELEM_W-1:0] q);
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return q - 1;
      3: return q;
      4: return q + 1;
      5: return ELEM_W'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random inner products of random length under one modulus. With open_tail set,
  // two pairs are left unclosed so the next modulus lands on a live sum.
  task automatic run_phase(input logic [ELEM_W-1:0] q, input int pairs, input bit open_tail);
    int sent;
    int len;
    write_modulus(q);
    sent = 0;
    while (sent < pairs) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) send_pair(pick_elem(q), pick_elem(q), k == len - 1);
      sent += len;
    end
    if (open_tail) repeat (2) send_pair(pick_elem(q), pick_elem(q), 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset modulus of 2, with the largest operands.
    send_pair(ALL_ONES, ALL_ONES, 1'b1);
    send_pair(64'd1, 64'd1, 1'b0);
    send_pair(64'd1, 64'd1, 1'b1);

    // Largest modulus: two residues of q-1 overflow the 64-bit sum.
    write_modulus(ALL_ONES);
    send_pair(ALL_ONES - 1, 64'd1, 1'b0);
    send_pair(ALL_ONES - 1, 64'd1, 1'b0);
    send_pair(ALL_ONES, ALL_ONES, 1'b1);
    send_pair('0, ALL_ONES, 1'b1);

    // Zero modulus wraps modulo 2^64.
    write_modulus('0);
    send_pair(ALL_ONES, ALL_ONES, 1'b0);
    send_pair(ALL_ONES, 64'd2, 1'b0);
    send_pair(64'h8000_0000_0000_0000, 64'd4, 1'b1);

    // Modulus of one forces every sum to zero.
    write_modulus(64'd1);
    send_pair(ALL_ONES, 64'd5, 1'b0);
    send_pair(64'd7, 64'd7, 1'b1);

    // Leave a large sum open, then shrink the modulus under it.
    write_modulus(64'h8000_0000_0000_0001);
    send_pair(64'h8000_0000_0000_0000, 64'd1, 1'b0);
    send_pair(64'h8000_0000_0000_0000, 64'd1, 1'b0);
    write_modulus(64'd3);
    send_pair('0, '0, 1'b1);

    // Random part, first with a slow receiver.
    run_phase({1'b1, 31'($urandom), $urandom}, 150, 1'b0);
    run_phase(ALL_ONES, 150, 1'b1);
    run_phase(ELEM_W'($urandom_range(2, 1000)), 150, 1'b0);

    // Then with a slow sender.
    send_idle = 88;
    recv_idle = 31;
    run_phase('0, 150, 1'b0);
    run_phase(64'd1, 100, 1'b0);
    run_phase(64'd1 << $urandom_range(1, 63), 150, 1'b1);

    // Then at full rate on both sides.
    send_idle = 0;
    recv_idle = 0;
    run_phase(MODULUS_RESET, 100, 1'b0);
    run_phase({$urandom, $urandom}, 250, 1'b0);

    drain();
    if (board.mismatches == 0 && board.dots_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
